[rtl/hk2a_pkg.sv]
// hk2a_pkg: shared types, constants and the US layout table for the HID
// keyboard usage to ASCII translator. No dependencies.
`timescale 1ns / 1ps

package hk2a_pkg;

   // Key history depth (slots per report)
   localparam int KEY_SLOTS = 6;
   localparam int CNT_W     = $clog2(KEY_SLOTS + 1);

   // Transaction modes
   typedef enum logic [1:0] {
      MODE_FIELD  = 2'd0,
      MODE_COMMIT = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Usage page and usage codes
   localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
   localparam logic [7:0]  USAGE_LCTRL   = 8'hE0;
   localparam logic [7:0]  USAGE_RCTRL   = 8'hE4;
   localparam logic [7:0]  USAGE_LSHIFT  = 8'hE1;
   localparam logic [7:0]  USAGE_RSHIFT  = 8'hE5;
   localparam logic [7:0]  USAGE_A       = 8'h04;
   localparam logic [7:0]  USAGE_Z       = 8'h1D;
   localparam logic [7:0]  USAGE_M       = 8'h10;
   localparam logic [7:0]  USAGE_INSERT  = 8'h49;
   localparam logic [7:0]  USAGE_DELETE  = 8'h4C;
   localparam logic [7:0]  USAGE_RIGHT   = 8'h4F;
   localparam logic [7:0]  USAGE_LEFT    = 8'h50;
   localparam logic [7:0]  USAGE_DOWN    = 8'h51;
   localparam logic [7:0]  USAGE_UP      = 8'h52;
   localparam logic [7:0]  USAGE_TAB_LO  = 8'h04;
   localparam logic [7:0]  USAGE_TAB_HI  = 8'h38;

   // Control codes
   localparam logic [6:0] CHAR_CTRL_M = 7'd28;

   // Translation result handed from the translator to the top level
   typedef struct packed {
      logic       hit;
      logic [6:0] ch;
   } xlate_result_type;

   // US layout lookup; returns {hit, char}. Valid for usages 0x04..0x38.
   function automatic logic [7:0] us_lookup(input logic [7:0] key, input logic shift);
      logic [7:0] res;
      res = 8'h00;
      if (key >= USAGE_A && key <= USAGE_Z) begin
         // letters
         res = shift ? {1'b1, 7'(key + 8'h3D)} : {1'b1, 7'(key + 8'h5D)};
      end else begin
         case (key)
            8'h1E: res = shift ? 8'hA1 : 8'hB1;
            8'h1F: res = shift ? 8'hC0 : 8'hB2;
            8'h20: res = shift ? 8'hA3 : 8'hB3;
            8'h21: res = shift ? 8'hA4 : 8'hB4;
            8'h22: res = shift ? 8'hA5 : 8'hB5;
            8'h23: res = shift ? 8'hDE : 8'hB6;
            8'h24: res = shift ? 8'hA6 : 8'hB7;
            8'h25: res = shift ? 8'hAA : 8'hB8;
            8'h26: res = shift ? 8'hA8 : 8'hB9;
            8'h27: res = shift ? 8'hA9 : 8'hB0;
            8'h28: res = 8'h8D;
            8'h29: res = 8'h9B;
            8'h2A: res = 8'h88;
            8'h2B: res = 8'h89;
            8'h2C: res = 8'hA0;
            8'h2D: res = shift ? 8'hDF : 8'hAD;
            8'h2E: res = shift ? 8'hAB : 8'hBD;
            8'h2F: res = shift ? 8'hFB : 8'hDB;
            8'h30: res = shift ? 8'hFD : 8'hDD;
            8'h31: res = shift ? 8'hFC : 8'hDC;
            8'h33: res = shift ? 8'hBA : 8'hBB;
            8'h34: res = shift ? 8'hA2 : 8'hA7;
            8'h35: res = shift ? 8'hFE : 8'hE0;
            8'h36: res = shift ? 8'hBC : 8'hAC;
            8'h37: res = shift ? 8'hBE : 8'hAE;
            8'h38: res = shift ? 8'hBF : 8'hAF;
            default: res = 8'h00;
         endcase
      end
      return res;
   endfunction

endpackage

[rtl/hk2a_translate.sv]
// hk2a_translate: maps one keyboard usage byte to a 7-bit character under the
// latched Ctrl and Shift state. Depends on hk2a_pkg.
`timescale 1ns / 1ps

module hk2a_translate import hk2a_pkg::*; (
   input  logic [7:0]       key,
   input  logic             ctrl,
   input  logic             shift,
   output xlate_result_type result
);

   logic [7:0] table_res;

   assign table_res = us_lookup(key, shift);

   // Pick by priority: Ctrl letter, navigation keys, layout table
   always_comb begin
      result = '0;
      if (ctrl && key >= USAGE_A && key <= USAGE_Z) begin
         result.hit = 1'b1;
         result.ch  = (key == USAGE_M) ? CHAR_CTRL_M : 7'(key - 8'd3);
      end else begin
         case (key)
            USAGE_INSERT: result = '{hit: 1'b1, ch: 7'h0F};
            USAGE_DELETE: result = '{hit: 1'b1, ch: 7'h07};
            USAGE_RIGHT:  result = '{hit: 1'b1, ch: 7'h04};
            USAGE_LEFT:   result = '{hit: 1'b1, ch: 7'h13};
            USAGE_DOWN:   result = '{hit: 1'b1, ch: 7'h18};
            USAGE_UP:     result = '{hit: 1'b1, ch: 7'h05};
            default: begin
               if (key >= USAGE_TAB_LO && key <= USAGE_TAB_HI) begin
                  result.hit = table_res[7];
                  result.ch  = table_res[6:0];
               end
            end
         endcase
      end
   end

endmodule

[rtl/hid_key_report_to_ascii_core.sv]
// hid_key_report_to_ascii_core: top level of the HID keyboard usage to ASCII
// translator. Depends on hk2a_pkg and hk2a_translate.
`timescale 1ns / 1ps

// Takes one parsed HID report field per transaction and returns zero or one
// 7-bit character per transaction, in order. A transaction is registered at
// the input, then processed against the key history and modifier latches as
// it moves into the result register, so the block takes a new transaction
// every cycle while rsp_stall is low; its character follows in the result
// register. The result register alone sets the rate: while a character waits
// under rsp_stall, the input register fills and req_stall rises. Mode 1
// commits the collected keys as the new history and clears the latches;
// mode 2 clears the history. No clearing pass follows reset.
module hid_key_report_to_ascii_core import hk2a_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_usage_page,
   input  logic [15:0] req_usage,
   input  logic        req_pressed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_ascii_char
);

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_mode_ff;
   logic [15:0] s1_page_ff;
   logic [15:0] s1_usage_ff;
   logic        s1_pressed_ff;

   // Key state
   logic [7:0]       held_ff [KEY_SLOTS];
   logic [7:0]       keys_ff [KEY_SLOTS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             shift_ff, shift_in;
   logic             ctrl_ff, ctrl_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_char_ff, rsp_char_in;

   logic             req_accept;
   logic             advance;
   logic             is_field;
   logic             is_commit;
   logic             is_clear;
   logic             is_ctrl_key;
   logic             is_shift_key;
   logic             is_key;
   logic             collect;
   logic             seen;
   logic [KEY_SLOTS-1:0] match;
   xlate_result_type xlate;

   // Handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;

   // Decode the held transaction
   assign is_commit    = advance && (mode_type'(s1_mode_ff) == MODE_COMMIT);
   assign is_clear     = advance && (mode_type'(s1_mode_ff) == MODE_CLEAR);
   assign is_field     = advance && (mode_type'(s1_mode_ff) == MODE_FIELD)
                         && (s1_page_ff == PAGE_KEYBOARD) && (s1_usage_ff != 16'd0);
   assign is_ctrl_key  = (s1_usage_ff == {8'd0, USAGE_LCTRL})
                         || (s1_usage_ff == {8'd0, USAGE_RCTRL});
   assign is_shift_key = (s1_usage_ff == {8'd0, USAGE_LSHIFT})
                         || (s1_usage_ff == {8'd0, USAGE_RSHIFT});
   assign is_key       = is_field && !is_ctrl_key && !is_shift_key;
   assign collect      = is_key && (count_ff < CNT_W'(KEY_SLOTS));

   // Compare the full usage against every history slot
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_match
      assign match[i] = (s1_usage_ff == {8'd0, held_ff[i]});
   end
   assign seen = |match;

   hk2a_translate u_translate (
      .key    (s1_usage_ff[7:0]),
      .ctrl   (ctrl_ff),
      .shift  (shift_ff),
      .result (xlate)
   );

   // Next values of latches, count and result
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      count_in     = count_ff;
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      if (is_commit) begin
         count_in = '0;
         shift_in = 1'b0;
         ctrl_in  = 1'b0;
      end
      if (is_field && is_ctrl_key && s1_pressed_ff) begin
         ctrl_in = 1'b1;
      end
      if (is_field && is_shift_key && s1_pressed_ff) begin
         shift_in = 1'b1;
      end
      if (collect) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (advance) begin
         rsp_valid_in = is_key && !seen && xlate.hit;
         rsp_char_in  = xlate.ch;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff    <= req_mode;
         s1_page_ff    <= req_usage_page;
         s1_usage_ff   <= req_usage;
         s1_pressed_ff <= req_pressed;
      end
      rsp_char_ff <= rsp_char_in;
   end

   // Per-slot history and collection
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            held_ff[i] <= 8'd0;
            keys_ff[i] <= 8'd0;
         end else if (is_commit) begin
            held_ff[i] <= keys_ff[i];
            keys_ff[i] <= 8'd0;
         end else begin
            if (is_clear) begin
               held_ff[i] <= 8'd0;
            end
            if (collect && count_ff == CNT_W'(i)) begin
               keys_ff[i] <= s1_usage_ff[7:0];
            end
         end
      end
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(KEY_SLOTS))
      else $error("key count beyond slot count");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      is_commit |=> (count_ff == '0) && !shift_ff && !ctrl_ff)
      else $error("commit did not clear the report state");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with nothing pending");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a processed transaction");

   a_no_result_on_modifier: assert property (@(posedge clock) disable iff (reset)
      advance && (is_ctrl_key || is_shift_key) |=> !rsp_valid_ff)
      else $error("modifier key produced a character");

endmodule

[tb/tb.sv]
// tb: self-checking testbench for hid_key_report_to_ascii_core.
// Depends on hk2a_pkg and the core RTL; predicts each character from its own
// model of the key history and modifier latches.
`timescale 1ns / 1ps

module tb;
   import hk2a_pkg::*;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] page;
      logic [15:0] usage;
      logic        pressed;
   } key_field_type;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 375;
   localparam int DRAIN_CYCLES    = 20;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode       = MODE_FIELD;
   logic [15:0] req_usage_page = 16'h0000;
   logic [15:0] req_usage      = 16'h0000;
   logic        req_pressed    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [6:0]  rsp_ascii_char;

   // Stimulus and checking state
   key_field_type field_queue [$];
   logic [6:0]  expected_chars [$];
   logic [15:0] last_report_usages [$];
   int          sender_idle_pct = 0;
   int          recv_stall_pct  = 0;
   int          fail_count      = 0;
   int          cycle_count     = 0;
   int          report_items    = 0;

   // Predictor state: committed history, report in progress, latches
   logic [7:0]  held_keys [KEY_SLOTS];
   logic [7:0]  collected_keys [KEY_SLOTS];
   int          collected_count = 0;
   bit          shift_on        = 1'b0;
   bit          ctrl_on         = 1'b0;

   hid_key_report_to_ascii_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_usage_page (req_usage_page),
      .req_usage      (req_usage),
      .req_pressed    (req_pressed),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char)
   );

   always #10 clock = ~clock;

   // US layout with Ctrl and navigation overrides; returns 0 for no character
   function automatic bit key_to_char(input logic [7:0] key, input bit shift, input bit ctrl,
                                      output logic [6:0] ch);
      string plain_digits;
      string shift_digits;
      string plain_punct;
      string shift_punct;
      bit    hit;
      plain_digits = "1234567890";
      shift_digits = "!@#$%^&*()";
      plain_punct  = "-=[]\\ ;'`,./";
      shift_punct  = "_+{}| :\"~<>?";
      hit = 1'b1;
      ch  = 7'h00;
      if (ctrl && key >= USAGE_A && key <= USAGE_Z) begin
         ch = (key == USAGE_M) ? CHAR_CTRL_M : 7'(key - 8'd3);
      end else begin
         case (key)
            USAGE_INSERT: ch = 7'h0F;
            USAGE_DELETE: ch = 7'h07;
            USAGE_RIGHT:  ch = 7'h04;
            USAGE_LEFT:   ch = 7'h13;
            USAGE_DOWN:   ch = 7'h18;
            USAGE_UP:     ch = 7'h05;
            8'h28:        ch = 7'h0D;
            8'h29:        ch = 7'h1B;
            8'h2A:        ch = 7'h08;
            8'h2B:        ch = 7'h09;
            8'h2C:        ch = 7'h20;
            default: begin
               if (key >= USAGE_A && key <= USAGE_Z)
                  ch = 7'((shift ? 8'h41 : 8'h61) + key - USAGE_A);
               else if (key >= 8'h1E && key <= 8'h27)
                  ch = 7'(shift ? shift_digits[int'(key) - 'h1E] : plain_digits[int'(key) - 'h1E]);
               else if (key >= 8'h2D && key <= USAGE_TAB_HI && key != 8'h32)
                  ch = 7'(shift ? shift_punct[int'(key) - 'h2D] : plain_punct[int'(key) - 'h2D]);
               else
                  hit = 1'b0;
            end
         endcase
      end
      return hit;
   endfunction

   // Advance the predictor by one accepted transaction
   task automatic predict_field(input logic [1:0] mode, input logic [15:0] page,
                                input logic [15:0] usage, input logic pressed);
      logic [6:0] ch;
      bit         held;
      held = 1'b0;
      case (mode)
         MODE_COMMIT: begin
            held_keys       = collected_keys;
            collected_keys  = '{default: 8'h00};
            collected_count = 0;
            shift_on        = 1'b0;
            ctrl_on         = 1'b0;
         end
         MODE_CLEAR: held_keys = '{default: 8'h00};
         MODE_FIELD: begin
            if (page == PAGE_KEYBOARD && usage != 16'h0000) begin
               if (usage == {8'h00, USAGE_LCTRL} || usage == {8'h00, USAGE_RCTRL}) begin
                  if (pressed) ctrl_on = 1'b1;
               end else if (usage == {8'h00, USAGE_LSHIFT} || usage == {8'h00, USAGE_RSHIFT}) begin
                  if (pressed) shift_on = 1'b1;
               end else begin
                  if (collected_count < KEY_SLOTS) begin
                     collected_keys[collected_count] = usage[7:0];
                     collected_count++;
                  end
                  // full 16-bit usage against 8-bit history: high usages never match
                  foreach (held_keys[i])
                     if (usage == {8'h00, held_keys[i]}) held = 1'b1;
                  if (!held && key_to_char(usage[7:0], shift_on, ctrl_on, ch))
                     expected_chars.push_back(ch);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_item(input logic [1:0] mode, input logic [15:0] page,
                             input logic [15:0] usage, input logic pressed);
      key_field_type f;
      f.mode    = mode;
      f.page    = page;
      f.usage   = usage;
      f.pressed = pressed;
      field_queue.push_back(f);
   endtask

   task automatic queue_key(input logic [15:0] usage, input logic pressed);
      queue_item(MODE_FIELD, PAGE_KEYBOARD, usage, pressed);
   endtask

   // One well-formed report: modifiers and keys, some held over, then a commit
   task automatic queue_report();
      logic [15:0] sent [$];
      logic [15:0] key;
      int          n_keys;
      int          r;
      n_keys = $urandom_range(0, 9);
      for (int i = 0; i < n_keys; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            case ($urandom_range(0, 3))
               0:       key = {8'h00, USAGE_LCTRL};
               1:       key = {8'h00, USAGE_RCTRL};
               2:       key = {8'h00, USAGE_LSHIFT};
               default: key = {8'h00, USAGE_RSHIFT};
            endcase
         end else if (r < 45 && last_report_usages.size() != 0)
            key = last_report_usages[$urandom_range(0, last_report_usages.size() - 1)];
         else if (r < 85)
            key = 16'($urandom_range(USAGE_A, USAGE_UP));
         else if (r < 95)
            key = 16'($urandom_range(0, 255));
         else
            key = 16'($urandom);
         queue_key(key, 1'($urandom_range(0, 1)));
         sent.push_back(key);
      end
      queue_item(MODE_COMMIT, 16'($urandom), 16'($urandom), 1'($urandom));
      last_report_usages = sent;
      report_items += n_keys + 1;
   endtask

   // Stray transactions: history clear, undefined mode, foreign pages, wild usages
   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0:       queue_item(MODE_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
         1:       queue_item(MODE_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
         2:       queue_item(MODE_FIELD, 16'($urandom), 16'($urandom), 1'($urandom));
         default: queue_key(16'($urandom), 1'($urandom));
      endcase
   endtask

   task automatic queue_directed();
      // plain, shifted, non-US hash, Ctrl letters, overflow past six keys
      queue_key(16'h0004, 1'b1);
      queue_key({8'h00, USAGE_LSHIFT}, 1'b1);
      queue_key(16'h001E, 1'b0);
      queue_key(16'h0032, 1'b1);
      queue_key(16'h0038, 1'b1);
      queue_key({8'h00, USAGE_RCTRL}, 1'b1);
      queue_key({8'h00, USAGE_M}, 1'b1);
      queue_key({8'h00, USAGE_Z}, 1'b1);
      queue_key({8'h00, USAGE_RIGHT}, 1'b1);
      queue_item(MODE_COMMIT, 16'hFFFF, 16'hFFFF, 1'b1);
      // held key, high usage, released modifiers, usage zero, foreign page, mode 3
      queue_key(16'h0004, 1'b1);
      queue_key(16'h0104, 1'b1);
      queue_key({8'h00, USAGE_LCTRL}, 1'b0);
      queue_key({8'h00, USAGE_RSHIFT}, 1'b0);
      queue_key({8'h00, USAGE_DELETE}, 1'b1);
      queue_key(16'h0000, 1'b1);
      queue_item(MODE_FIELD, 16'h0008, 16'h0005, 1'b1);
      queue_item(MODE_NONE, PAGE_KEYBOARD, 16'h0005, 1'b1);
      // link lost mid-report, then keys that were held become new again
      queue_item(MODE_CLEAR, 16'h0000, 16'h0000, 1'b0);
      queue_key(16'h0004, 1'b1);
      queue_key({8'h00, USAGE_INSERT}, 1'b1);
      queue_key({8'h00, USAGE_UP}, 1'b1);
      queue_key(16'hFFFF, 1'b1);
      queue_item(MODE_COMMIT, 16'h0000, 16'h0000, 1'b0);
      queue_key({8'h00, USAGE_LEFT}, 1'b1);
      queue_key({8'h00, USAGE_DOWN}, 1'b1);
      queue_item(MODE_COMMIT, 16'h0000, 16'h0000, 1'b0);
   endtask

   // Driver: hold a stalled transaction, otherwise maybe idle or load the next one
   always @(posedge clock) begin : drive_proc
      key_field_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_field(req_mode, req_usage_page, req_usage, req_pressed);
         if (!req_valid || !req_stall) begin
            if (field_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               f = field_queue.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= f.mode;
               req_usage_page <= f.page;
               req_usage      <= f.usage;
               req_pressed    <= f.pressed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted character with the oldest prediction
   always @(posedge clock) begin : check_proc
      logic [6:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("rsp_ascii_char: expected none, got %h", rsp_ascii_char);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ascii_char !== want) begin
                  $error("rsp_ascii_char: expected %h, got %h", want, rsp_ascii_char);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      held_keys      = '{default: 8'h00};
      collected_keys = '{default: 8'h00};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin sender_idle_pct = 75; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (phase == 0) queue_directed();
         report_items = 0;
         while (report_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 12) queue_noise();
            queue_report();
         end
         // hold off the next phase until every transaction is in and every character out
         while (field_queue.size() != 0 || req_valid || expected_chars.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
